FILE: src/bas_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and helpers of the bumper avoidance sequencer
package bas_pkg;

  localparam int unsigned TickW    = 16;
  localparam int unsigned NumRegs  = 6;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned PaddrW   = 5;
  localparam int unsigned PdataW   = 32;
  localparam int unsigned DriveW   = 3;
  localparam int unsigned CauseW   = 3;

  typedef enum logic [RegIdxW-1:0] {
    REG_REV_SHORT = 3'd0,
    REG_TRN_SHORT = 3'd1,
    REG_REV_BOTH  = 3'd2,
    REG_TRN_BOTH  = 3'd3,
    REG_REV_SIDE  = 3'd4,
    REG_TRN_SIDE  = 3'd5
  } bas_reg_e;

  typedef enum logic [DriveW-1:0] {
    DRV_STOP  = 3'd0,
    DRV_FWD   = 3'd1,
    DRV_REV   = 3'd2,
    DRV_LEFT  = 3'd3,
    DRV_RIGHT = 3'd4
  } bas_drive_e;

  typedef enum logic [CauseW-1:0] {
    CAUSE_NONE       = 3'd0,
    CAUSE_BOTH_FRONT = 3'd1,
    CAUSE_FRONT_LEFT = 3'd2,
    CAUSE_FRONT_RGHT = 3'd3,
    CAUSE_SIDE_LEFT  = 3'd4,
    CAUSE_SIDE_RGHT  = 3'd5
  } bas_cause_e;

  typedef enum logic [3:0] {
    PH_CRUISE  = 4'b0001,
    PH_REVERSE = 4'b0010,
    PH_TURN    = 4'b0100,
    PH_DONE    = 4'b1000
  } bas_phase_e;

  typedef logic [TickW-1:0] bas_tick_t;

  typedef struct packed {
    bas_tick_t rev_short;
    bas_tick_t trn_short;
    bas_tick_t rev_both;
    bas_tick_t trn_both;
    bas_tick_t rev_side;
    bas_tick_t trn_side;
  } bas_cfg_t;

  localparam bas_tick_t RegResetVals [NumRegs] = '{
    16'd1250, 16'd1500, 16'd2000, 16'd3000, 16'd4000, 16'd3000
  };

  // zero duration counts as one tick
  function automatic bas_tick_t at_least_one(input bas_tick_t v);
    return (v == '0) ? bas_tick_t'(1) : v;
  endfunction

  // remaining ticks after the first one of a phase
  function automatic bas_tick_t ticks_after_first(input bas_tick_t v);
    return (v == '0) ? '0 : v - bas_tick_t'(1);
  endfunction

endpackage

FILE: src/bas_if.sv
`timescale 1ns / 1ps
// request channels of the bumper avoidance sequencer
interface bas_in_if;
  import bas_pkg::*;
  logic valid;
  logic ready;
  logic front_right_level;
  logic front_left_level;
  logic side_left_level;
  logic side_right_level;
  logic remote_level;

  modport source (
    output valid, front_right_level, front_left_level, side_left_level,
           side_right_level, remote_level,
    input  ready
  );
  modport sink (
    input  valid, front_right_level, front_left_level, side_left_level,
           side_right_level, remote_level,
    output ready
  );
endinterface

interface bas_out_if;
  import bas_pkg::*;
  logic              valid;
  logic              ready;
  logic [DriveW-1:0] motor_drive;
  logic [CauseW-1:0] trigger_cause;
  logic              finished;

  modport source (
    output valid, motor_drive, trigger_cause, finished,
    input  ready
  );
  modport sink (
    input  valid, motor_drive, trigger_cause, finished,
    output ready
  );
endinterface

FILE: src/bas_cfg_regs.sv
`timescale 1ns / 1ps
// apb register file holding the six phase durations
module bas_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bas_pkg::PaddrW-1:0] paddr,
  input  logic [bas_pkg::PdataW-1:0] pwdata,
  output logic [bas_pkg::PdataW-1:0] prdata,
  output logic                      pready,
  output bas_pkg::bas_cfg_t         cfg_o
);
  import bas_pkg::*;

  bas_tick_t            regs_q [NumRegs];
  logic [RegIdxW-1:0]   idx;
  logic                 idx_ok;
  logic                 wr_en;

  assign idx    = paddr[PaddrW-1:2];
  assign idx_ok = (idx < RegIdxW'(NumRegs));
  assign wr_en  = psel && penable && pwrite && idx_ok;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        regs_q[i] <= RegResetVals[i];
      end
    end else if (wr_en) begin
      regs_q[idx] <= pwdata[TickW-1:0];
    end
  end

  assign prdata = idx_ok ? {{(PdataW-TickW){1'b0}}, regs_q[idx]} : '0;

  assign cfg_o.rev_short = regs_q[REG_REV_SHORT];
  assign cfg_o.trn_short = regs_q[REG_TRN_SHORT];
  assign cfg_o.rev_both  = regs_q[REG_REV_BOTH];
  assign cfg_o.trn_both  = regs_q[REG_TRN_BOTH];
  assign cfg_o.rev_side  = regs_q[REG_REV_SIDE];
  assign cfg_o.trn_side  = regs_q[REG_TRN_SIDE];

endmodule

FILE: src/bas_core.sv
`timescale 1ns / 1ps
// per-tick phase sequencer with registered drive result
module bas_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bas_pkg::bas_cfg_t cfg_i,
  bas_in_if.sink            in_i,
  bas_out_if.source         out_o
);
  import bas_pkg::*;

  bas_phase_e phase_q, phase_d;
  bas_tick_t  cnt_q, cnt_d;
  bas_tick_t  pend_q, pend_d;
  logic       right_q, right_d;

  logic       out_valid_q;
  bas_drive_e drive_q, drive;
  bas_cause_e cause_q, cause, trig;
  logic       fin_q;

  logic       fr, fl, sl, sr, rem;
  bas_tick_t  sel_rev, sel_trn, turn_cnt;
  logic       sel_right;
  logic       accept;

  assign fr  = !in_i.front_right_level;
  assign fl  = !in_i.front_left_level;
  assign sl  = !in_i.side_left_level;
  assign sr  = !in_i.side_right_level;
  assign rem = !in_i.remote_level;

  // output register frees up when the result is taken
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // trigger priority
  always_comb begin
    trig      = CAUSE_NONE;
    sel_rev   = '0;
    sel_trn   = '0;
    sel_right = 1'b0;
    if (fr && fl) begin
      trig = CAUSE_BOTH_FRONT; sel_rev = cfg_i.rev_both; sel_trn = cfg_i.trn_both;
    end else if (fl) begin
      trig = CAUSE_FRONT_LEFT; sel_rev = cfg_i.rev_short; sel_trn = cfg_i.trn_short;
      sel_right = 1'b1;
    end else if (fr) begin
      trig = CAUSE_FRONT_RGHT; sel_rev = cfg_i.rev_short; sel_trn = cfg_i.trn_short;
    end else if (sl) begin
      trig = CAUSE_SIDE_LEFT; sel_rev = cfg_i.rev_side; sel_trn = cfg_i.trn_side;
    end else if (sr) begin
      trig = CAUSE_SIDE_RGHT; sel_rev = cfg_i.rev_side; sel_trn = cfg_i.trn_side;
      sel_right = 1'b1;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    pend_d   = pend_q;
    right_d  = right_q;
    drive    = DRV_STOP;
    cause    = CAUSE_NONE;
    turn_cnt = cnt_q;
    case (phase_q)
      PH_CRUISE: begin
        if (trig != CAUSE_NONE) begin
          cause   = trig;
          phase_d = PH_REVERSE;
          cnt_d   = ticks_after_first(sel_rev);
          pend_d  = at_least_one(sel_trn);
          right_d = sel_right;
          drive   = DRV_REV;
        end else if (rem) begin
          phase_d = PH_DONE;
        end else begin
          drive = DRV_FWD;
        end
      end
      PH_REVERSE, PH_TURN: begin
        if (phase_q == PH_REVERSE && cnt_q != '0) begin
          cnt_d = cnt_q - bas_tick_t'(1);
          drive = DRV_REV;
        end else begin
          // last reverse tick doubles as the first turn tick
          if (phase_q == PH_REVERSE) begin
            turn_cnt = ticks_after_first(pend_q);
          end
          drive = right_q ? DRV_RIGHT : DRV_LEFT;
          if (turn_cnt != '0) begin
            phase_d = PH_TURN;
            cnt_d   = turn_cnt - bas_tick_t'(1);
          end else begin
            phase_d = PH_CRUISE;
            cnt_d   = '0;
            if (rem) begin
              phase_d = PH_DONE;
              drive   = DRV_STOP;
            end
          end
        end
      end
      PH_DONE: begin
        drive = DRV_STOP;
      end
      default: begin
        drive = DRV_STOP;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_CRUISE;
      cnt_q       <= '0;
      pend_q      <= '0;
      right_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (accept) begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      right_q     <= right_d;
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      drive_q <= drive;
      cause_q <= cause;
      fin_q   <= (phase_d == PH_DONE);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.motor_drive   = drive_q;
  assign out_o.trigger_cause = cause_q;
  assign out_o.finished      = fin_q;

`ifndef SYNTHESIS
  a_done_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DONE |=> phase_q == PH_DONE)
    else $error("finished state left without reset");

  a_cause_reverses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && cause_q != CAUSE_NONE |-> drive_q == DRV_REV)
    else $error("trigger reported without reverse drive");

  a_finished_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && fin_q |-> drive_q == DRV_STOP && cause_q == CAUSE_NONE)
    else $error("motors driven after finish");

  a_result_on_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted request produced no result");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty output register");
`endif

endmodule

FILE: src/bumper_avoidance_sequencer.sv
`timescale 1ns / 1ps
// bumper avoidance sequencer top level
// result: the drive result of an accepted request is valid in the next cycle
// throughput: one request per cycle unless the output stalls; the register
//   takes the next result in the same cycle that the previous one is taken
// reset: asynchronous active low, clears phase to cruise and restores the
//   duration registers to their defaults
module bumper_avoidance_sequencer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  bas_in_if.sink                     in_i,
  bas_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bas_pkg::PaddrW-1:0] paddr,
  input  logic [bas_pkg::PdataW-1:0] pwdata,
  output logic [bas_pkg::PdataW-1:0] prdata,
  output logic                       pready
);
  import bas_pkg::*;

  bas_cfg_t cfg;

  bas_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bas_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule
